>>> hdl/dag_longest_path_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the longest path core
// Shared shorthand for clocked implications with reset disable.
// ----------------------------------------------------------------------------
`ifndef DAG_LONGEST_PATH_CORE_DEFINES_SVH
`define DAG_LONGEST_PATH_CORE_DEFINES_SVH

// Same-cycle implication
`define DLP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define DLP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/dlp_pkg.sv
// ----------------------------------------------------------------------------
// dlp_pkg
// Types and constants shared by the longest path core modules.
// ----------------------------------------------------------------------------
package dlp_pkg;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_POP_LD,
      ST_RELAX_ROW,
      ST_RELAX_V,
      ST_RELAX_DV,
      ST_RELAX_RD,
      ST_RELAX_CHK,
      ST_MAX_RD,
      ST_MAX_CHK,
      ST_OUT
   } state_type;

   // Shared compare unit operations
   typedef enum logic {
      ALU_RELAX,
      ALU_MAX
   } alu_op_type;

   // Request function codes
   localparam logic FUNC_EDGE   = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   // Register indexes
   localparam logic REG_NODE_COUNT  = 1'b0;
   localparam logic REG_SOURCE_NODE = 1'b1;

   // Distance codes
   localparam logic signed [7:0] DIST_NONE = 8'shff;
   localparam logic signed [7:0] DIST_MAX  = 8'sd127;
   localparam logic signed [7:0] DIST_ZERO = 8'sd0;

   // Result handed from the sequencer to the output register
   typedef struct packed {
      logic signed [7:0] length;
      logic [7:0]        node;
      logic              ok;
   } result_type;

endpackage

>>> hdl/dlp_ram.sv
// ----------------------------------------------------------------------------
// dlp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hdl/dlp_alu.sv
// ----------------------------------------------------------------------------
// dlp_alu
// Shared saturating increment and signed compare for relax and max search.
// ----------------------------------------------------------------------------
module dlp_alu
   import dlp_pkg::*;
(
   input  alu_op_type        op,
   input  logic signed [7:0] a,
   input  logic signed [7:0] b,
   output logic signed [7:0] value,
   output logic              greater
);

   // Increment with saturation for relax, pass through for max
   always_comb begin
      unique case (op)
         ALU_RELAX: value = (a == DIST_MAX) ? DIST_MAX : a + 8'sd1;
         ALU_MAX:   value = a;
         default:   value = a;
      endcase
      greater = (value > b);
   end

endmodule

>>> hdl/dlp_seq.sv
// ----------------------------------------------------------------------------
// dlp_seq
// Sequencer: edge loading, stack based depth-first postorder, relaxation in
// reverse postorder, max search and adjacency clearing.
// ----------------------------------------------------------------------------
module dlp_seq
   import dlp_pkg::*;
#(
   parameter int MAX_NODES = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] node_count,
   input  logic [7:0] source_node,
   input  logic       req_valid,
   input  logic       req_func,
   input  logic [7:0] req_from_node,
   input  logic [7:0] req_to_node,
   output logic       req_stall,
   input  logic       out_free,
   output logic       res_load,
   output result_type res
);

   localparam int AW  = $clog2(MAX_NODES);
   localparam int NW  = $clog2(MAX_NODES + 1);
   localparam int AAW = 2 * AW;
   localparam int SW  = AW + NW;

   state_type state_ff, state_in;
   logic [AAW-1:0] clr_ff, clr_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic [MAX_NODES-1:0] dval_ff, dval_in;
   logic [NW-1:0] root_ff, root_in;
   logic [AW-1:0] cur_v_ff, cur_v_in;
   logic [NW-1:0] cur_i_ff, cur_i_in;
   logic [AW-1:0] sp_ff, sp_in;
   logic [NW-1:0] pc_ff, pc_in;
   logic [NW-1:0] k_ff, k_in;
   logic [AW-1:0] v_ff, v_in;
   logic signed [7:0] dv_ff, dv_in;
   logic [NW-1:0] j_ff, j_in;
   logic signed [7:0] best_ff, best_in;
   logic [NW-1:0] bnode_ff, bnode_in;
   result_type res_ff, res_in;

   logic [NW-1:0] n;
   logic          s_ok, edge_ok, take, scan_end, push_ok, j_end;
   logic [AW-1:0] s_idx;
   logic signed [7:0] dj, dv_now;

   logic            adj_we, adj_wdata, adj_re, adj_rdata;
   logic [AAW-1:0]  adj_waddr, adj_raddr;
   logic            stk_we, stk_re;
   logic [AW-1:0]   stk_waddr, stk_raddr;
   logic [SW-1:0]   stk_wdata, stk_rdata;
   logic            post_we, post_re;
   logic [AW-1:0]   post_waddr, post_raddr, post_rdata;
   logic            dist_we, dist_re;
   logic [AW-1:0]   dist_waddr, dist_raddr;
   logic [7:0]      dist_wdata, dist_rdata;

   alu_op_type        alu_op;
   logic signed [7:0] alu_a, alu_b, alu_val;
   logic              alu_gt;

   // Clamp node count to the storage size
   always_comb begin
      if (32'(node_count) > 32'(MAX_NODES)) begin
         n = NW'(MAX_NODES);
      end else begin
         n = NW'(node_count);
      end
   end

   assign s_ok    = (source_node != 8'd0) && (32'(source_node) <= 32'(n));
   assign s_idx   = AW'(source_node - 8'd1);
   assign edge_ok = (req_from_node != 8'd0) && (32'(req_from_node) <= 32'(n)) &&
                    (req_to_node != 8'd0) && (32'(req_to_node) <= 32'(n));
   assign take     = (state_ff == ST_IDLE) && req_valid;
   assign scan_end = (cur_i_ff == n);
   assign push_ok  = adj_rdata && !visited_ff[cur_i_ff[AW-1:0]];
   assign j_end    = (j_ff == n);
   assign dj       = dval_ff[j_ff[AW-1:0]] ? $signed(dist_rdata) : DIST_NONE;
   assign dv_now   = dval_ff[v_ff] ? $signed(dist_rdata) : DIST_NONE;

   // Shared compare unit
   assign alu_op = (state_ff == ST_MAX_CHK) ? ALU_MAX : ALU_RELAX;
   assign alu_a  = (state_ff == ST_MAX_CHK) ? dj : dv_ff;
   assign alu_b  = (state_ff == ST_MAX_CHK) ? best_ff : dj;

   dlp_alu u_alu (
      .op      (alu_op),
      .a       (alu_a),
      .b       (alu_b),
      .value   (alu_val),
      .greater (alu_gt)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == {AAW{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take && req_func == FUNC_FINISH) state_in = s_ok ? ST_ROOT : ST_OUT;
         end
         ST_ROOT: begin
            if (root_ff == n) begin
               state_in = ST_RELAX_ROW;
            end else if (!visited_ff[root_ff[AW-1:0]]) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (!scan_end) begin
               state_in = ST_SCAN_CHK;
            end else if (sp_ff == '0) begin
               state_in = ST_ROOT;
            end else begin
               state_in = ST_POP_LD;
            end
         end
         ST_SCAN_CHK:  state_in = ST_SCAN_RD;
         ST_POP_LD:    state_in = ST_SCAN_RD;
         ST_RELAX_ROW: state_in = (k_ff == '0) ? ST_MAX_RD : ST_RELAX_V;
         ST_RELAX_V:   state_in = ST_RELAX_DV;
         ST_RELAX_DV:  state_in = dv_now[7] ? ST_RELAX_ROW : ST_RELAX_RD;
         ST_RELAX_RD:  state_in = j_end ? ST_RELAX_ROW : ST_RELAX_CHK;
         ST_RELAX_CHK: state_in = ST_RELAX_RD;
         ST_MAX_RD:    state_in = j_end ? ST_OUT : ST_MAX_CHK;
         ST_MAX_CHK:   state_in = ST_MAX_RD;
         ST_OUT: begin
            if (out_free) state_in = ST_CLEAR;
         end
         default:      state_in = ST_CLEAR;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      clr_in     = clr_ff;
      visited_in = visited_ff;
      dval_in    = dval_ff;
      root_in    = root_ff;
      cur_v_in   = cur_v_ff;
      cur_i_in   = cur_i_ff;
      sp_in      = sp_ff;
      pc_in      = pc_ff;
      k_in       = k_ff;
      v_in       = v_ff;
      dv_in      = dv_ff;
      j_in       = j_ff;
      best_in    = best_ff;
      bnode_in   = bnode_ff;
      res_in     = res_ff;
      adj_we     = 1'b0;
      adj_waddr  = clr_ff;
      adj_wdata  = 1'b0;
      adj_re     = 1'b0;
      adj_raddr  = {cur_v_ff, cur_i_ff[AW-1:0]};
      stk_we     = 1'b0;
      stk_waddr  = sp_ff;
      stk_wdata  = {cur_v_ff, NW'(cur_i_ff + 1'b1)};
      stk_re     = 1'b0;
      stk_raddr  = AW'(sp_ff - 1'b1);
      post_we    = 1'b0;
      post_waddr = pc_ff[AW-1:0];
      post_re    = 1'b0;
      post_raddr = AW'(k_ff - 1'b1);
      dist_we    = 1'b0;
      dist_waddr = j_ff[AW-1:0];
      dist_wdata = alu_val;
      dist_re    = 1'b0;
      dist_raddr = j_ff[AW-1:0];
      res_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep zeros through the adjacency matrix
            adj_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (take && req_func == FUNC_EDGE && edge_ok) begin
               adj_we    = 1'b1;
               adj_waddr = {AW'(req_from_node - 8'd1), AW'(req_to_node - 8'd1)};
               adj_wdata = 1'b1;
            end
            if (take && req_func == FUNC_FINISH) begin
               visited_in = '0;
               dval_in    = '0;
               root_in    = '0;
               pc_in      = '0;
               res_in     = '{length: DIST_NONE, node: 8'd0, ok: 1'b0};
            end
         end
         ST_ROOT: begin
            if (root_ff == n) begin
               // Seed the source and start the reverse walk
               dist_we    = 1'b1;
               dist_waddr = s_idx;
               dist_wdata = DIST_ZERO;
               dval_in[s_idx] = 1'b1;
               k_in       = pc_ff;
            end else if (visited_ff[root_ff[AW-1:0]]) begin
               root_in = root_ff + 1'b1;
            end else begin
               visited_in[root_ff[AW-1:0]] = 1'b1;
               cur_v_in = root_ff[AW-1:0];
               cur_i_in = '0;
               sp_in    = '0;
            end
         end
         ST_SCAN_RD: begin
            if (!scan_end) begin
               adj_re = 1'b1;
            end else begin
               // Retire the node and drop back to its parent
               post_we = 1'b1;
               pc_in   = pc_ff + 1'b1;
               if (sp_ff != '0) begin
                  stk_re = 1'b1;
                  sp_in  = sp_ff - 1'b1;
               end
            end
         end
         ST_SCAN_CHK: begin
            if (push_ok) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + 1'b1;
               visited_in[cur_i_ff[AW-1:0]] = 1'b1;
               cur_v_in = cur_i_ff[AW-1:0];
               cur_i_in = '0;
            end else begin
               cur_i_in = cur_i_ff + 1'b1;
            end
         end
         ST_POP_LD: begin
            {cur_v_in, cur_i_in} = stk_rdata;
         end
         ST_RELAX_ROW: begin
            if (k_ff == '0) begin
               j_in     = '0;
               best_in  = DIST_NONE;
               bnode_in = '0;
            end else begin
               post_re = 1'b1;
               k_in    = k_ff - 1'b1;
            end
         end
         ST_RELAX_V: begin
            v_in       = post_rdata;
            dist_re    = 1'b1;
            dist_raddr = post_rdata;
         end
         ST_RELAX_DV: begin
            dv_in = dv_now;
            j_in  = '0;
         end
         ST_RELAX_RD: begin
            if (!j_end) begin
               adj_re    = 1'b1;
               adj_raddr = {v_ff, j_ff[AW-1:0]};
               dist_re   = 1'b1;
            end
         end
         ST_RELAX_CHK: begin
            if (adj_rdata && alu_gt) begin
               dist_we = 1'b1;
               dval_in[j_ff[AW-1:0]] = 1'b1;
               // A self-loop raises the running source distance too
               if (j_ff[AW-1:0] == v_ff) dv_in = alu_val;
            end
            j_in = j_ff + 1'b1;
         end
         ST_MAX_RD: begin
            if (j_end) begin
               res_in = '{length: best_ff, node: 8'(bnode_ff), ok: 1'b1};
            end else begin
               dist_re = 1'b1;
            end
         end
         ST_MAX_CHK: begin
            if (alu_gt) begin
               best_in  = dj;
               bnode_in = j_ff + 1'b1;
            end
            j_in = j_ff + 1'b1;
         end
         ST_OUT: begin
            if (out_free) begin
               res_load = 1'b1;
               clr_in   = '0;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign res       = res_ff;

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         visited_ff <= '0;
         dval_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         visited_ff <= visited_in;
         dval_ff    <= dval_in;
      end
      root_ff  <= root_in;
      cur_v_ff <= cur_v_in;
      cur_i_ff <= cur_i_in;
      sp_ff    <= sp_in;
      pc_ff    <= pc_in;
      k_ff     <= k_in;
      v_ff     <= v_in;
      dv_ff    <= dv_in;
      j_ff     <= j_in;
      best_ff  <= best_in;
      bnode_ff <= bnode_in;
      res_ff   <= res_in;
   end

   // Adjacency bit matrix, row = tail, column = head
   dlp_ram #(.WIDTH(1), .DEPTH(1 << AAW)) u_adj (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_en   (adj_re),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   // Search stack below the top entry
   dlp_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stk (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // Postorder list
   dlp_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_post (
      .clock   (clock),
      .wr_en   (post_we),
      .wr_addr (post_waddr),
      .wr_data (cur_v_ff),
      .rd_en   (post_re),
      .rd_addr (post_raddr),
      .rd_data (post_rdata)
   );

   // Distances
   dlp_ram #(.WIDTH(8), .DEPTH(MAX_NODES)) u_dist (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_en   (dist_re),
      .rd_addr (dist_raddr),
      .rd_data (dist_rdata)
   );

endmodule

>>> hdl/dag_longest_path_core.sv
// Edge transaction: one per cycle while idle, no result.
// Finish transaction: depth-first search, relaxation of each row in reverse postorder and the max
// search, then the result waits for the output register and the adjacency RAM is swept clear.
// The sweep writes one bit of the adjacency RAM per cycle.
// Reset (synchronous, active high) starts the same sweep; req_stall stays high meanwhile.
// Registers reset to node_count 1 and source_node 1.
// ----------------------------------------------------------------------------
// dag_longest_path_core
// Longest unit-weight path from a source node, with APB-style register port.
// ----------------------------------------------------------------------------
module dag_longest_path_core
   import dlp_pkg::*;
#(
   parameter int MAX_NODES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [7:0]        req_from_node,
   input  logic [7:0]        req_to_node,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_longest_length,
   output logic [7:0]        rsp_end_node,
   output logic              rsp_valid_res
);

   logic [7:0] node_count_ff, node_count_in;
   logic [7:0] source_node_ff, source_node_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       csr_wr, out_free, res_load;
   result_type res;

   // Register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      node_count_in  = node_count_ff;
      source_node_in = source_node_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_NODE_COUNT:  node_count_in  = csr_pwdata[7:0];
            REG_SOURCE_NODE: source_node_in = csr_pwdata[7:0];
            default:         node_count_in  = node_count_ff;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_paddr[2])
         REG_NODE_COUNT:  csr_prdata = {24'd0, node_count_ff};
         REG_SOURCE_NODE: csr_prdata = {24'd0, source_node_ff};
         default:         csr_prdata = '0;
      endcase
   end

   dlp_seq #(.MAX_NODES(MAX_NODES)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .node_count    (node_count_ff),
      .source_node   (source_node_ff),
      .req_valid     (req_valid),
      .req_func      (req_func),
      .req_from_node (req_from_node),
      .req_to_node   (req_to_node),
      .req_stall     (req_stall),
      .out_free      (out_free),
      .res_load      (res_load),
      .res           (res)
   );

   // Output register: load on a new result, drop once taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= 8'd1;
         source_node_ff <= 8'd1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         node_count_ff  <= node_count_in;
         source_node_ff <= source_node_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_longest_length = rsp_ff.length;
   assign rsp_end_node       = rsp_ff.node;
   assign rsp_valid_res      = rsp_ff.ok;

endmodule

>>> hdl/dlp_checker.sv
// ----------------------------------------------------------------------------
// dlp_checker
// Port-level checks for the longest path core, bound to the top level.
// ----------------------------------------------------------------------------
`include "dag_longest_path_core_defines.svh"

module dlp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_func,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [7:0] rsp_longest_length,
   input logic [7:0]        rsp_end_node,
   input logic              rsp_valid_res
);

   // Stalled result holds
   `DLP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_longest_length) && $stable(rsp_end_node) && $stable(rsp_valid_res), "stalled result changed")

   // Bad source gives the empty result
   `DLP_ASSERT_IMP(a_bad_source, clock, reset, rsp_valid && !rsp_valid_res, rsp_longest_length == -8'sd1 && rsp_end_node == 8'd0, "bad source result not empty")

   // Good source always reaches itself
   `DLP_ASSERT_IMP(a_good_source, clock, reset, rsp_valid && rsp_valid_res, rsp_end_node != 8'd0 && !rsp_longest_length[7], "good source result empty")

   // Finish transaction occupies the block
   `DLP_ASSERT_NXT(a_finish_busy, clock, reset, req_valid && !req_stall && req_func, req_stall, "ready right after finish")

   // Edge transaction leaves the block ready
   `DLP_ASSERT_NXT(a_edge_ready, clock, reset, req_valid && !req_stall && !req_func, !req_stall, "stalled after edge")

endmodule

bind dag_longest_path_core dlp_checker u_dlp_checker (.*);

>>> tb/dag_longest_path_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dag_longest_path_core_checker
// Watches the register port and both channels, keeps a shadow adjacency
// matrix and register copy, predicts each finish result and compares it.
// ----------------------------------------------------------------------------
module dag_longest_path_core_checker
   import dlp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   input  logic              csr_pready,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_func,
   input  logic [7:0]        req_from_node,
   input  logic [7:0]        req_to_node,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic signed [7:0] rsp_longest_length,
   input  logic [7:0]        rsp_end_node,
   input  logic              rsp_valid_res,
   output int                fail_count,
   output int                paths_waiting,
   output int                paths_checked
);

   localparam int NODES = 128;

   // shadow copies of the graph and the registers
   bit         edge_bits [1:NODES][1:NODES];
   logic [7:0] shadow_count;
   logic [7:0] shadow_source;
   result_type path_queue [$];

   assign paths_waiting = path_queue.size();

   task automatic report(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic int used_count();
      return (shadow_count > NODES) ? NODES : int'(shadow_count);
   endfunction

   // DFS postorder with explicit stack, one relax pass in reverse order
   function automatic result_type longest_path();
      result_type r;
      int         n, s, sp, v, i, k, j, nd, best, best_node, done;
      bit         seen [1:NODES];
      int         order [0:NODES];
      int         stk_node [0:NODES];
      int         stk_next [0:NODES];
      int         dist_len [0:NODES];
      bit         pushed;
      n = used_count();
      s = int'(shadow_source);
      best = -1;
      best_node = 0;
      r.ok = 1'b0;
      if (s >= 1 && s <= n) begin
         foreach (seen[x]) seen[x] = 0;
         done = 0;
         for (int root = 1; root <= n; root++) begin
            if (seen[root]) continue;
            seen[root] = 1;
            stk_node[0] = root;
            stk_next[0] = 1;
            sp = 1;
            while (sp > 0) begin
               v = stk_node[sp-1];
               pushed = 0;
               for (i = stk_next[sp-1]; i <= n; i++) begin
                  if (edge_bits[v][i] && !seen[i]) begin
                     stk_next[sp-1] = i + 1;
                     seen[i] = 1;
                     if (sp <= NODES) begin
                        stk_node[sp] = i;
                        stk_next[sp] = 1;
                        sp++;
                     end
                     pushed = 1;
                     break;
                  end
               end
               if (!pushed) begin
                  if (done < NODES + 1) order[done++] = v;
                  sp--;
               end
            end
         end
         foreach (dist_len[x]) dist_len[x] = -1;
         dist_len[s] = 0;
         for (k = done; k >= 1; k--) begin
            v = order[k-1];
            for (j = 1; j <= n; j++) begin
               if (edge_bits[v][j] && dist_len[v] >= 0) begin
                  nd = dist_len[v] + 1;
                  if (nd > 127) nd = 127;
                  if (nd > dist_len[j]) dist_len[j] = nd;
               end
            end
         end
         for (j = 1; j <= n; j++) begin
            if (dist_len[j] > best) begin
               best = dist_len[j];
               best_node = j;
            end
         end
         r.ok = 1'b1;
      end
      r.length = best[7:0];
      r.node   = best_node[7:0];
      return r;
   endfunction

   // track registers, load edges, predict and compare on each clock
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         shadow_count  <= 8'd1;
         shadow_source <= 8'd1;
         foreach (edge_bits[a, b]) edge_bits[a][b] = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_NODE_COUNT) shadow_count <= csr_pwdata[7:0];
            else shadow_source <= csr_pwdata[7:0];
         end
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_EDGE) begin
               if (req_from_node >= 1 && req_from_node <= used_count() &&
                   req_to_node >= 1 && req_to_node <= used_count())
                  edge_bits[req_from_node][req_to_node] = 1;
            end else begin
               path_queue.push_back(longest_path());
               foreach (edge_bits[a, b]) edge_bits[a][b] = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (path_queue.size() == 0) begin
               report("result with nothing expected");
            end else begin
               want = path_queue.pop_front();
               paths_checked++;
               if (rsp_longest_length !== want.length)
                  report($sformatf("longest_length %0d, expected %0d",
                                   rsp_longest_length, want.length));
               if (rsp_end_node !== want.node)
                  report($sformatf("end_node %0d, expected %0d", rsp_end_node, want.node));
               if (rsp_valid_res !== want.ok)
                  report($sformatf("valid_res %0b, expected %0b", rsp_valid_res, want.ok));
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      paths_checked = 0;
   end

endmodule

>>> tb/tb_dag_longest_path_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dag_longest_path_core
// Loads directed and random graphs under several node counts and sources,
// with random gaps and stalls on both channels; the checker predicts paths.
// ----------------------------------------------------------------------------
module tb_dag_longest_path_core;
   import dlp_pkg::*;

   // sweep of the adjacency RAM after a result or reset, plus margin
   localparam int SWEEP_WAIT = 17000;

   logic              clock = 0;
   logic              reset = 1;
   logic              csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;
   logic              req_valid = 0, req_stall;
   logic              req_func = FUNC_EDGE;
   logic [7:0]        req_from_node = '0, req_to_node = '0;
   logic              rsp_valid, rsp_stall = 0;
   logic signed [7:0] rsp_longest_length;
   logic [7:0]        rsp_end_node;
   logic              rsp_valid_res;
   int                fail_count, paths_waiting, paths_checked;
   int                sent_items = 0;
   int                graphs = 0;
   bit                gaps_on = 1;
   int                count_now = 1;

   always #2 clock = ~clock;

   dag_longest_path_core dut (.*);

   dag_longest_path_core_checker checker_i (.*);

   // random result stall, drawn for each transaction
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         hold = gaps_on ? $urandom_range(0, 10) : 0;
         if (hold > 0) begin
            rsp_stall = 1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // register write: setup cycle then access cycle, called at a falling edge
   task automatic reg_write(input logic index, input logic [7:0] value);
      csr_psel   = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr  = {index, 2'b00};
      csr_pwdata = {24'd0, value};
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      if (index == REG_NODE_COUNT) count_now = int'(value);
   endtask

   // hold off, present one transaction, advance once accepted
   task automatic send(input logic func, input logic [7:0] tail, input logic [7:0] head);
      int gap;
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1;
      req_func      = func;
      req_from_node = tail;
      req_to_node   = head;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_items++;
      if (func == FUNC_FINISH) graphs++;
   endtask

   // drain results and the clearing sweep before touching registers
   task automatic settle();
      req_valid = 0;
      while (paths_waiting != 0) @(negedge clock);
      repeat (SWEEP_WAIT) @(negedge clock);
   endtask

   task automatic random_graph(input int edges);
      int lim;
      lim = (count_now > 128) ? 128 : count_now;
      if (lim < 1) lim = 1;
      repeat (edges) begin
         if ($urandom_range(0, 9) == 0)
            send(FUNC_EDGE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         else
            send(FUNC_EDGE, 8'($urandom_range(1, lim)), 8'($urandom_range(1, lim)));
      end
      send(FUNC_FINISH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int n, pick;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;
      repeat (SWEEP_WAIT) @(negedge clock);

      // self-loop on the only node under reset registers
      send(FUNC_EDGE, 8'd1, 8'd1);
      send(FUNC_FINISH, 8'd0, 8'd0);
      settle();

      // empty graph
      reg_write(REG_NODE_COUNT, 8'd0);
      send(FUNC_EDGE, 8'd0, 8'd0);
      send(FUNC_FINISH, 8'hff, 8'hff);
      settle();

      // count above the maximum, out-of-range endpoints, cycle, repeated edge
      reg_write(REG_NODE_COUNT, 8'd255);
      reg_write(REG_SOURCE_NODE, 8'd128);
      send(FUNC_EDGE, 8'd128, 8'd1);
      send(FUNC_EDGE, 8'd1, 8'd2);
      send(FUNC_EDGE, 8'd2, 8'd1);
      send(FUNC_EDGE, 8'd1, 8'd2);
      send(FUNC_EDGE, 8'd0, 8'd5);
      send(FUNC_EDGE, 8'd5, 8'd0);
      send(FUNC_EDGE, 8'd129, 8'd3);
      send(FUNC_EDGE, 8'd255, 8'd255);
      send(FUNC_EDGE, 8'd2, 8'd128);
      send(FUNC_FINISH, 8'd0, 8'd0);
      settle();

      // source beyond the count
      reg_write(REG_NODE_COUNT, 8'd5);
      reg_write(REG_SOURCE_NODE, 8'd7);
      send(FUNC_EDGE, 8'd1, 8'd2);
      send(FUNC_FINISH, 8'd0, 8'd0);
      settle();

      // source zero
      reg_write(REG_SOURCE_NODE, 8'd0);
      send(FUNC_FINISH, 8'd0, 8'd0);
      settle();

      // full chain with a self-loop at its end saturates the distance
      reg_write(REG_NODE_COUNT, 8'd128);
      reg_write(REG_SOURCE_NODE, 8'd1);
      gaps_on = 0;
      for (int k = 1; k < 128; k++) send(FUNC_EDGE, k[7:0], 8'(k + 1));
      send(FUNC_EDGE, 8'd128, 8'd128);
      send(FUNC_FINISH, 8'd0, 8'd0);
      settle();

      // random phases: mostly small graphs, some large, some odd registers
      while (sent_items < 1050) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 19);
         if (pick == 0) n = $urandom_range(100, 128);
         else if (pick == 1) n = $urandom_range(129, 255);
         else n = $urandom_range(2, 12);
         reg_write(REG_NODE_COUNT, n[7:0]);
         pick = $urandom_range(0, 9);
         if (pick == 0) reg_write(REG_SOURCE_NODE, 8'($urandom_range(0, 255)));
         else reg_write(REG_SOURCE_NODE, 8'($urandom_range(1, (n > 128) ? 128 : n)));
         repeat ($urandom_range(2, 4)) random_graph($urandom_range(0, 40));
         settle();
      end

      $display("sent %0d transactions forming %0d graphs, %0d path results checked",
               sent_items, graphs, paths_checked);
      $display("covered empty, oversized, invalid-source, cyclic and saturating graphs");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #400_000_000;
      $display("timeout");
      $display("status: fail");
      $finish;
   end

endmodule
